[sv/scd_pkg.sv]
// Package for the set-1 scan code decoder: result types, event codes and
// the layout key tables. No dependencies.
package scd_pkg;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_CONSOLE = 2'd1;
  localparam logic [1:0] KIND_LED = 2'd2;

  localparam logic LAYOUT_SPANISH = 1'b0;
  localparam logic LAYOUT_ENGLISH = 1'b1;

  localparam logic [7:0] CODE_RELEASE_BIT = 8'h80;
  localparam logic [7:0] CODE_LSHIFT_UP = 8'hAA;
  localparam logic [7:0] CODE_RSHIFT_UP = 8'hB6;
  localparam logic [7:0] CODE_F1 = 8'h3B;
  localparam logic [7:0] CODE_F8 = 8'h42;
  localparam logic [7:0] CODE_LSHIFT = 8'h2A;
  localparam logic [7:0] CODE_RSHIFT = 8'h36;
  localparam logic [7:0] CODE_CAPS = 8'h3A;
  localparam logic [7:0] CODE_TABLE_END = 8'h51;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] ch;
    logic [2:0] con;
    logic [2:0] led;
  } result_t;

  typedef struct packed {
    logic    has_result;
    result_t res;
  } decode_t;

  // t = {layout, shifted}: Spanish plain, Spanish shifted, English plain, English shifted
  function automatic logic [6:0] pick(input logic [1:0] t, input logic [7:0] a,
                                      input logic [7:0] b, input logic [7:0] c,
                                      input logic [7:0] d);
    logic [7:0] r;
    case (t)
      2'd0: r = a;
      2'd1: r = b;
      2'd2: r = c;
      default: r = d;
    endcase
    return r[6:0];
  endfunction

  function automatic logic [6:0] letter(input logic sh, input logic [7:0] lower);
    logic [7:0] r;
    r = sh ? (lower - 8'h20) : lower;
    return r[6:0];
  endfunction

  function automatic logic [6:0] key_char(input logic eng, input logic sh,
                                          input logic [6:0] idx);
    logic [1:0] t;
    logic [6:0] c;
    t = {eng, sh};
    case (idx)
      7'd0: c = 7'h1B;
      7'd1: c = pick(t, "@", "#", 8'h60, "~");
      7'd2: c = pick(t, "1", "!", "1", "+");
      7'd3: c = pick(t, "2", "\"", "2", "@");
      7'd4: c = pick(t, "3", "-", "3", "#");
      7'd5: c = pick(t, "4", "$", "4", "$");
      7'd6: c = pick(t, "5", "%", "5", "%");
      7'd7: c = pick(t, "6", "&", "6", "^");
      7'd8: c = pick(t, "7", "/", "7", "&");
      7'd9: c = pick(t, "8", "(", "8", "*");
      7'd10: c = pick(t, "9", ")", "9", "(");
      7'd11: c = pick(t, "0", "=", "0", ")");
      7'd12: c = pick(t, "#", "?", "-", "_");
      7'd13: c = pick(t, "*", "@", "=", "+");
      7'd14: c = 7'h08;
      7'd15: c = 7'h09;
      7'd16: c = letter(sh, "q");
      7'd17: c = letter(sh, "w");
      7'd18: c = letter(sh, "e");
      7'd19: c = letter(sh, "r");
      7'd20: c = letter(sh, "t");
      7'd21: c = letter(sh, "y");
      7'd22: c = letter(sh, "u");
      7'd23: c = letter(sh, "i");
      7'd24: c = letter(sh, "o");
      7'd25: c = letter(sh, "p");
      7'd26: c = pick(t, 8'h60, "^", "[", "{");
      7'd27: c = pick(t, "+", "*", "]", "}");
      7'd28: c = 7'h0A;
      7'd30: c = letter(sh, "a");
      7'd31: c = letter(sh, "s");
      7'd32: c = letter(sh, "d");
      7'd33: c = letter(sh, "f");
      7'd34: c = letter(sh, "g");
      7'd35: c = letter(sh, "h");
      7'd36: c = letter(sh, "j");
      7'd37: c = letter(sh, "k");
      7'd38: c = letter(sh, "l");
      7'd39: c = pick(t, "{", "\"", ";", ":");
      7'd40: c = pick(t, "#", "+", "#", "\"");
      7'd41: c = pick(t, "}", "@", "\\", "|");
      7'd43: c = pick(t, "<", ">", "<", ">");
      7'd44: c = letter(sh, "z");
      7'd45: c = letter(sh, "x");
      7'd46: c = letter(sh, "c");
      7'd47: c = letter(sh, "v");
      7'd48: c = letter(sh, "b");
      7'd49: c = letter(sh, "n");
      7'd50: c = letter(sh, "m");
      7'd51: c = pick(t, ",", ";", ",", "<");
      7'd52: c = pick(t, ".", ":", ".", ">");
      7'd53: c = pick(t, "-", "_", "/", "?");
      7'd57: c = 7'h20;
      7'd59: c = 7'h31;
      7'd60: c = 7'h32;
      7'd61: c = 7'h33;
      7'd62: c = 7'h34;
      7'd63: c = 7'h35;
      7'd64: c = 7'h36;
      7'd65: c = 7'h37;
      7'd66: c = 7'h38;
      7'd67: c = 7'h39;
      7'd68: c = 7'h30;
      7'd72: c = 7'h11;
      7'd75: c = 7'h12;
      7'd77: c = 7'h12;
      7'd80: c = 7'h13;
      default: c = 7'h40;
    endcase
    return c;
  endfunction

endpackage

[sv/scd_decode.sv]
// Decode stage: shift and caps flags plus the combinational scan code decode.
// Depends on scd_pkg.
module scd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              layout,
  input  logic [7:0]        code,
  input  logic              advance,
  output scd_pkg::decode_t  dec
);
  import scd_pkg::*;

  logic       shift_held;
  logic       caps_on;
  logic       shift_held_next;
  logic       caps_on_next;
  logic       is_release;
  logic       is_fkey;
  logic       is_shift;
  logic       is_caps;
  logic       is_filtered;
  logic [6:0] raw_ch;
  logic [6:0] ch;
  logic [7:0] fkey_off;

  assign is_release = (code & CODE_RELEASE_BIT) != 8'h00;
  assign is_fkey = !is_release && code >= CODE_F1 && code <= CODE_F8;
  assign is_shift = code == CODE_LSHIFT || code == CODE_RSHIFT;
  assign is_caps = code == CODE_CAPS;
  assign is_filtered = (code inside {8'h01, 8'h0F, 8'h1D, 8'h38, 8'h47, 8'h49, 8'h4F,
                                     8'h51, 8'h53}) || code >= CODE_TABLE_END;
  assign fkey_off = code - CODE_F1;
  assign raw_ch = key_char(layout, shift_held, code[6:0]);

  always_comb begin
    ch = raw_ch;
    if (caps_on && !shift_held && (raw_ch inside {[7'h61:7'h7A]})) begin
      ch = raw_ch - 7'h20;
    end else if (caps_on && shift_held && (raw_ch inside {[7'h41:7'h5A]})) begin
      ch = raw_ch + 7'h20;
    end
  end

  always_comb begin
    dec = '0;
    shift_held_next = shift_held;
    caps_on_next = caps_on;
    if (is_release) begin
      if (code == CODE_LSHIFT_UP || code == CODE_RSHIFT_UP) begin
        shift_held_next = 1'b0;
      end
    end else if (is_fkey) begin
      dec.has_result = 1'b1;
      dec.res.kind = KIND_CONSOLE;
      dec.res.con = fkey_off[2:0];
    end else if (is_shift) begin
      shift_held_next = 1'b1;
    end else if (is_caps) begin
      caps_on_next = !caps_on;
      dec.has_result = 1'b1;
      dec.res.kind = KIND_LED;
      dec.res.led = {!caps_on, 2'b00};
    end else if (!is_filtered) begin
      dec.has_result = 1'b1;
      dec.res.kind = KIND_CHAR;
      dec.res.ch = ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      caps_on <= 1'b0;
    end else if (advance) begin
      shift_held <= shift_held_next;
      caps_on <= caps_on_next;
    end
  end

endmodule

[sv/scd_out_stage.sv]
// Result register holding one decoded event until the consumer takes it.
// Depends on scd_pkg.
module scd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  scd_pkg::result_t  res,
  input  logic              ready,
  output logic              valid,
  output logic              free,
  output scd_pkg::result_t  res_q
);
  import scd_pkg::*;

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      res_q <= res;
    end
  end

endmodule

[sv/scan_code_to_ascii_decoder_unit.sv]
// Set-1 scan code to console event decoder, top level.
// Path: an accepted item passes through the input register, then the result register.
// Throughput: one item per cycle; stalls only when the result register is full
// and not being taken while the input register holds an item with a result.
// Reset (rst, synchronous): empties both registers, clears shift and caps,
// selects the Spanish layout. Depends on scd_pkg, scd_decode, scd_out_stage.
module scan_code_to_ascii_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_data,
  input  logic       scan_valid,
  output logic       scan_ready,
  input  logic [7:0] scan_code,
  output logic       event_valid,
  input  logic       event_ready,
  output logic [1:0] event_kind,
  output logic [6:0] char_code,
  output logic [2:0] console_index,
  output logic [2:0] led_mask
);
  import scd_pkg::*;

  logic       layout;
  logic       code_valid;
  logic [7:0] code;
  logic       advance;
  logic       out_free;
  decode_t    dec;
  result_t    res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      layout <= LAYOUT_SPANISH;
    end else if (cfg_we) begin
      layout <= cfg_data[0];
    end
  end

  assign advance = code_valid && (!dec.has_result || out_free);
  assign scan_ready = !code_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (scan_ready) begin
      code_valid <= scan_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_ready && scan_valid) begin
      code <= scan_code;
    end
  end

  scd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .layout  (layout),
    .code    (code),
    .advance (advance),
    .dec     (dec)
  );

  scd_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (advance && dec.has_result),
    .res   (dec.res),
    .ready (event_ready),
    .valid (event_valid),
    .free  (out_free),
    .res_q (res_q)
  );

  assign event_kind = res_q.kind;
  assign char_code = res_q.ch;
  assign console_index = res_q.con;
  assign led_mask = res_q.led;

endmodule

[sv/scd_checker.sv]
// Port-level checks for the scan code decoder, bound to the top level.
// Depends on scd_pkg and scan_code_to_ascii_decoder_unit.
module scd_checker (
  input logic       clk,
  input logic       rst,
  input logic       event_valid,
  input logic       event_ready,
  input logic [1:0] event_kind,
  input logic [6:0] char_code,
  input logic [2:0] console_index,
  input logic [2:0] led_mask
);
  import scd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && !event_ready |=> event_valid && $stable(event_kind) &&
      $stable(char_code) && $stable(console_index) && $stable(led_mask))
    else $error("stalled item changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !event_valid)
    else $error("item shown right after reset");

  a_kind_char: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_kind == KIND_CHAR |-> console_index == 3'd0 && led_mask == 3'd0)
    else $error("character item carries other fields");

  a_kind_console: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_kind == KIND_CONSOLE |-> char_code == 7'd0 && led_mask == 3'd0)
    else $error("console item carries other fields");

  a_kind_led: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> event_kind != 2'd3 &&
      (event_kind != KIND_LED || (char_code == 7'd0 && console_index == 3'd0 &&
       led_mask[1:0] == 2'b00)))
    else $error("bad LED item or kind");

endmodule

bind scan_code_to_ascii_decoder_unit scd_checker u_scd_checker (
  .clk           (clk),
  .rst           (rst),
  .event_valid   (event_valid),
  .event_ready   (event_ready),
  .event_kind    (event_kind),
  .char_code     (char_code),
  .console_index (console_index),
  .led_mask      (led_mask)
);
